// ----- rtl/core/mono_framebuffer_draw_engine_defines.svh -----
// Assertion macros for the monochrome framebuffer draw engine.
// Used by the top level only; every macro expects clk and rst in scope.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mfb_pkg.sv -----
// Shared types and constants for the monochrome framebuffer draw engine.
// No dependencies; imported by the walker, the frame memory and the top level.
`timescale 1ns / 1ps

package mfb_pkg;

  // Signed working coordinate, wide enough for corner plus size sums.
  typedef logic signed [14:0] crd_t;

  // One drawing job for the walker: a clipped rectangle or a line.
  typedef struct packed {
    logic       is_line;
    crd_t       x0;
    crd_t       y0;
    crd_t       w;
    crd_t       h;
    crd_t       x1;
    crd_t       y1;
    logic       on;
    logic       pattern;
    logic [7:0] level;
  } walk_job_t;

  // Operation that travels with one frame memory request.
  typedef struct packed {
    logic       read;
    logic [2:0] bit_sel;
    logic       on;
  } fb_op_t;

  // Command opcodes.
  localparam logic [2:0] OP_POINT = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_FRAME = 3'd3;
  localparam logic [2:0] OP_LEVEL = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // Drawing phases of one command.
  localparam logic [2:0] PH_SINGLE   = 3'd0;
  localparam logic [2:0] PH_TOP      = 3'd1;
  localparam logic [2:0] PH_BOTTOM   = 3'd2;
  localparam logic [2:0] PH_LEFT     = 3'd3;
  localparam logic [2:0] PH_RIGHT    = 3'd4;
  localparam logic [2:0] PH_INTERIOR = 3'd5;

  // Configuration register indexes and reset values.
  localparam logic [7:0] REG_ACTIVE_WIDTH  = 8'd0;
  localparam logic [7:0] REG_ACTIVE_HEIGHT = 8'd1;
  localparam logic [7:0] ACTIVE_WIDTH_RST  = 8'd128;
  localparam logic [6:0] ACTIVE_HEIGHT_RST = 7'd64;

  // Largest legal level bar size.
  localparam logic signed [11:0] LEVEL_SIZE_MAX = 12'sd257;

endpackage

// ----- rtl/core/mfb_frame_mem.sv -----
// Frame store: byte memory with a read-modify-write pixel port and a clearing pass.
// Depends on mfb_pkg for the request operation type.
`timescale 1ns / 1ps

module mfb_frame_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic [AW-1:0]  req_addr,
  input  mfb_pkg::fb_op_t req_op,
  output logic           rd_valid,
  output logic [7:0]     rd_data,
  output logic           clearing
);
  import mfb_pkg::*;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          busy;
  fb_op_t        op_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    rdata;
  logic          accept;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [7:0]    mask;

  // A request is read, then written back; none is taken while clearing or busy.
  assign req_ready = !clearing && !busy;
  assign accept    = req_valid && req_ready;

  // Clearing pass after reset and the busy flag of the write-back cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      busy     <= 1'b0;
    end else begin
      busy <= accept;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req_op;
      addr_q <= req_addr;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[req_addr];
    end
  end

  // Modified byte for the write-back of a pixel.
  assign mask = 8'd1 << op_q.bit_sel;
  assign we   = clearing || (busy && !op_q.read);
  assign wa   = clearing ? clr_addr : addr_q;
  assign wd   = clearing ? 8'd0 : (op_q.on ? (rdata | mask) : (rdata & ~mask));

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign rd_valid = busy && op_q.read;
  assign rd_data  = rdata;

endmodule

// ----- rtl/core/mfb_walker.sv -----
// Pixel walker: steps a clipped rectangle or a Bresenham line one pixel at a time.
// Depends on mfb_pkg; feeds pixel requests to the frame memory.
`timescale 1ns / 1ps

module mfb_walker #(
  parameter int FB_WIDTH = 128,
  parameter int AW       = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mfb_pkg::walk_job_t job,
  input  logic [8:0]         lw,
  input  logic [8:0]         lh,
  output logic               busy,
  output logic               done,
  output logic               pix_valid,
  input  logic               pix_ready,
  output logic [AW-1:0]      pix_addr,
  output mfb_pkg::fb_op_t    pix_op
);
  import mfb_pkg::*;

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_RECT = 3'b010,
    W_LINE = 3'b100
  } walk_state_t;

  walk_state_t state;
  walk_job_t   job_q;

  // Rectangle walk registers.
  logic [8:0] cx, cs, ce, cy, re;
  // Line walk registers.
  crd_t       lx, ly;
  logic [12:0] m, ldx, ldy, lcnt, lcount;
  logic        sx_neg, sy_neg, steep;

  // Setup terms.
  crd_t lw_s, lh_s, cs_c, ce_raw, ce_c, rs_c, re_raw, re_c, adx, ady;
  logic rect_empty, steep_c;

  // Line step terms.
  logic        inrange, line_adv, carry, step_x, step_y;
  logic [13:0] acc;
  logic [12:0] lim, m_next;
  crd_t        lx_next, ly_next;

  // Pixel terms.
  crd_t       cx_s, i_full;
  logic [7:0] iv, px, py;
  logic       jpar, pat_on, color;

  assign lw_s = {6'b0, lw};
  assign lh_s = {6'b0, lh};

  // Clip the rectangle against the active area; also the line deltas and slope.
  always_comb begin
    cs_c       = job.x0[14] ? '0 : job.x0;
    ce_raw     = job.x0 + job.w;
    ce_c       = (ce_raw > lw_s) ? lw_s : ce_raw;
    rs_c       = job.y0[14] ? '0 : job.y0;
    re_raw     = job.y0 + job.h;
    re_c       = (re_raw > lh_s) ? lh_s : re_raw;
    rect_empty = (ce_c <= cs_c) || (re_c <= rs_c);
    adx        = (job.x1 >= job.x0) ? (job.x1 - job.x0) : (job.x0 - job.x1);
    ady        = (job.y1 >= job.y0) ? (job.y1 - job.y0) : (job.y0 - job.y1);
    steep_c    = !(adx > ady);
  end

  // Shared error-term adder and compare of the line walk.
  always_comb begin
    inrange = !lx[14] && (lx < lw_s) && !ly[14] && (ly < lh_s);
    acc     = {1'b0, m} + {1'b0, (steep ? ldx : ldy)};
    lim     = steep ? ldy : ldx;
    carry   = acc >= {1'b0, lim};
    m_next  = carry ? 13'(acc - {1'b0, lim}) : acc[12:0];
    step_x  = steep ? carry : 1'b1;
    step_y  = steep ? 1'b1 : carry;
    lx_next = lx + (step_x ? (sx_neg ? -15'sd1 : 15'sd1) : 15'sd0);
    ly_next = ly + (step_y ? (sy_neg ? -15'sd1 : 15'sd1) : 15'sd0);
    line_adv = (state == W_LINE) && (!inrange || pix_ready);
  end

  // Pixel color, including the checkered level pattern.
  always_comb begin
    cx_s   = {6'b0, cx};
    i_full = cx_s - job_q.x0;
    iv     = i_full[7:0];
    jpar   = cy[0] ^ job_q.y0[0];
    pat_on = (iv < job_q.level) ? (iv[0] ^ jpar)
                                : ((iv == job_q.level) && (iv != 8'd0));
    color  = ((state == W_RECT) && job_q.pattern) ? pat_on : job_q.on;
    px     = (state == W_RECT) ? cx[7:0] : lx[7:0];
    py     = (state == W_RECT) ? cy[7:0] : ly[7:0];
  end

  assign pix_valid      = (state == W_RECT) || ((state == W_LINE) && inrange);
  assign pix_addr       = AW'(FB_WIDTH * int'(py[7:3]) + int'(px));
  assign pix_op.read    = 1'b0;
  assign pix_op.bit_sel = py[2:0];
  assign pix_op.on      = color;
  assign busy           = (state != W_IDLE);

  // Walk sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (start) begin
            job_q <= job;
            if (job.is_line) begin
              lx     <= job.x0;
              ly     <= job.y0;
              m      <= '0;
              ldx    <= adx[12:0];
              ldy    <= ady[12:0];
              lcnt   <= '0;
              lcount <= steep_c ? ady[12:0] : adx[12:0];
              sx_neg <= job.x1 < job.x0;
              sy_neg <= job.y1 < job.y0;
              steep  <= steep_c;
              state  <= W_LINE;
            end else if (rect_empty) begin
              done <= 1'b1;
            end else begin
              cx    <= cs_c[8:0];
              cs    <= cs_c[8:0];
              ce    <= ce_c[8:0];
              cy    <= rs_c[8:0];
              re    <= re_c[8:0];
              state <= W_RECT;
            end
          end
        end
        W_RECT: begin
          if (pix_ready) begin
            if ((cx + 9'd1) == ce) begin
              cx <= cs;
              if ((cy + 9'd1) == re) begin
                done  <= 1'b1;
                state <= W_IDLE;
              end else begin
                cy <= cy + 9'd1;
              end
            end else begin
              cx <= cx + 9'd1;
            end
          end
        end
        W_LINE: begin
          if (line_adv) begin
            lx <= lx_next;
            ly <= ly_next;
            m  <= m_next;
            if (lcnt == lcount) begin
              done  <= 1'b1;
              state <= W_IDLE;
            end else begin
              lcnt <= lcnt + 13'd1;
            end
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/mono_framebuffer_draw_engine.sv -----
// Top level of the monochrome framebuffer draw engine.
// Depends on mfb_pkg, mfb_walker, mfb_frame_mem and the assertion macro header.
//
// Usage: commands arrive on the in_valid/in_ready channel, one request per
// command, and each command returns exactly one result request on
// out_valid/out_ready (read_data for a byte read, error for a bad level bar).
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is the active width, index 1 the active height, others are ignored.
// Every drawn pixel is a byte read, then a write back, through the single
// memory port; a clipped line point is stepped over without a memory
// request, and each rectangle or edge is set up in the T_LAUNCH state
// before it is walked.
// Only the visible part of a rectangle is walked. One command is in flight
// at a time; in_ready is low from acceptance until its result is taken or
// parked in the output register, and it stays low while a result waits.
// Reset: a clearing pass writes zero to every byte of the frame store, one
// byte a cycle (FB_WIDTH * ceil(FB_HEIGHT / 8) bytes, 1024 by default);
// no command is accepted meanwhile, configuration writes are.
// A stalled receiver holds the result in the output register.
`timescale 1ns / 1ps
`include "mono_framebuffer_draw_engine_defines.svh"

module mono_framebuffer_draw_engine #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [11:0] x_a,
  input  logic signed [11:0] y_a,
  input  logic signed [11:0] x_b,
  input  logic signed [11:0] y_b,
  input  logic signed [11:0] rect_width,
  input  logic signed [11:0] rect_height,
  input  logic               color,
  input  logic [7:0]         level,
  input  logic [9:0]         read_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         read_data,
  output logic               error
);
  import mfb_pkg::*;

  localparam int DEPTH = FB_WIDTH * ((FB_HEIGHT + 7) / 8);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0] FBW9 = 9'(FB_WIDTH);
  localparam logic [8:0] FBH9 = 9'(FB_HEIGHT);

  typedef enum logic [4:0] {
    T_IDLE      = 5'b00001,
    T_LAUNCH    = 5'b00010,
    T_DRAW      = 5'b00100,
    T_READ_REQ  = 5'b01000,
    T_READ_WAIT = 5'b10000
  } top_state_t;

  top_state_t state;
  logic [2:0] phase;
  logic [7:0] active_width;
  logic [6:0] active_height;
  logic [8:0] lw, lh;

  // Latched command.
  logic [2:0] op_q;
  crd_t       x_q, y_q, xb_q, yb_q, w_q, h_q;
  logic       on_q;
  logic [7:0] level_q;
  logic [9:0] addr_q;

  walk_job_t  job;
  logic       walk_start, walk_busy, walk_done;
  logic       pix_valid, pix_ready;
  logic [AW-1:0] pix_addr;
  fb_op_t     pix_op;

  logic          mem_req_valid, mem_req_ready, mem_rd_valid, clearing;
  logic [AW-1:0] mem_req_addr;
  fb_op_t        mem_req_op;
  logic [7:0]    mem_rd_data;

  logic in_accept, level_bad, addr_ok, bar_inner;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= ACTIVE_WIDTH_RST;
      active_height <= ACTIVE_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ACTIVE_WIDTH) begin
        active_width <= cfg_data;
      end else if (cfg_index == REG_ACTIVE_HEIGHT) begin
        active_height <= cfg_data[6:0];
      end
    end
  end

  // Clip limits: the smaller of the register and the framebuffer size.
  assign lw = ({1'b0, active_width} < FBW9) ? {1'b0, active_width} : FBW9;
  assign lh = ({2'b0, active_height} < FBH9) ? {2'b0, active_height} : FBH9;

  assign in_ready  = (state == T_IDLE) && !out_valid && !clearing;
  assign in_accept = in_valid && in_ready;
  assign level_bad = (rect_width < 12'sd0) || (rect_width > LEVEL_SIZE_MAX)
                  || (rect_height < 12'sd0) || (rect_height > LEVEL_SIZE_MAX);
  assign addr_ok   = 32'(read_address) < 32'(DEPTH);
  assign bar_inner = (w_q > 15'sd2) && (h_q > 15'sd2);

  // Job for the current phase.
  always_comb begin
    job.is_line = (phase == PH_SINGLE) && (op_q == OP_LINE);
    job.x1      = xb_q;
    job.y1      = yb_q;
    job.on      = (op_q == OP_LEVEL) ? 1'b1 : on_q;
    job.pattern = 1'b0;
    job.level   = level_q;
    job.x0      = x_q;
    job.y0      = y_q;
    job.w       = w_q;
    job.h       = h_q;
    unique case (phase)
      PH_SINGLE: begin
        if (op_q == OP_POINT) begin
          job.w = 15'sd1;
          job.h = 15'sd1;
        end
      end
      PH_TOP: job.h = 15'sd1;
      PH_BOTTOM: begin
        job.y0 = y_q + h_q - 15'sd1;
        job.h  = 15'sd1;
      end
      PH_LEFT: job.w = 15'sd1;
      PH_RIGHT: begin
        job.x0 = x_q + w_q - 15'sd1;
        job.w  = 15'sd1;
      end
      PH_INTERIOR: begin
        job.x0      = x_q + 15'sd1;
        job.y0      = y_q + 15'sd1;
        job.w       = w_q - 15'sd2;
        job.h       = h_q - 15'sd2;
        job.pattern = 1'b1;
      end
      default: begin
        job.w = 15'sd0;
      end
    endcase
  end

  // Command sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      phase     <= PH_SINGLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_accept) begin
            read_data <= 8'd0;
            error     <= 1'b0;
            phase     <= PH_SINGLE;
            priority case (opcode)
              OP_POINT, OP_LINE, OP_FILL: state <= T_LAUNCH;
              OP_FRAME: begin
                phase <= PH_TOP;
                state <= T_LAUNCH;
              end
              OP_LEVEL: begin
                if (level_bad) begin
                  error     <= 1'b1;
                  out_valid <= 1'b1;
                end else begin
                  phase <= PH_TOP;
                  state <= T_LAUNCH;
                end
              end
              OP_READ: begin
                if (addr_ok) begin
                  state <= T_READ_REQ;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        T_LAUNCH: state <= T_DRAW;
        T_DRAW: begin
          if (walk_done) begin
            priority case (phase)
              PH_TOP: begin
                phase <= PH_BOTTOM;
                state <= T_LAUNCH;
              end
              PH_BOTTOM: begin
                phase <= PH_LEFT;
                state <= T_LAUNCH;
              end
              PH_LEFT: begin
                phase <= PH_RIGHT;
                state <= T_LAUNCH;
              end
              PH_RIGHT: begin
                if ((op_q == OP_LEVEL) && bar_inner) begin
                  phase <= PH_INTERIOR;
                  state <= T_LAUNCH;
                end else begin
                  out_valid <= 1'b1;
                  state     <= T_IDLE;
                end
              end
              default: begin
                out_valid <= 1'b1;
                state     <= T_IDLE;
              end
            endcase
          end
        end
        T_READ_REQ: begin
          if (mem_req_ready) begin
            state <= T_READ_WAIT;
          end
        end
        T_READ_WAIT: begin
          if (mem_rd_valid) begin
            read_data <= mem_rd_data;
            out_valid <= 1'b1;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Command payload capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q    <= opcode;
      x_q     <= crd_t'(x_a);
      y_q     <= crd_t'(y_a);
      xb_q    <= crd_t'(x_b);
      yb_q    <= crd_t'(y_b);
      w_q     <= crd_t'(rect_width);
      h_q     <= crd_t'(rect_height);
      on_q    <= color;
      level_q <= level;
      addr_q  <= read_address;
    end
  end

  assign walk_start = (state == T_LAUNCH);

  mfb_walker #(
    .FB_WIDTH (FB_WIDTH),
    .AW       (AW)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (walk_start),
    .job       (job),
    .lw        (lw),
    .lh        (lh),
    .busy      (walk_busy),
    .done      (walk_done),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_addr  (pix_addr),
    .pix_op    (pix_op)
  );

  // Memory port: byte read for the read command, pixels otherwise.
  always_comb begin
    mem_req_valid      = pix_valid;
    mem_req_addr       = pix_addr;
    mem_req_op         = pix_op;
    if (state == T_READ_REQ) begin
      mem_req_valid      = 1'b1;
      mem_req_addr       = AW'(addr_q);
      mem_req_op.read    = 1'b1;
      mem_req_op.bit_sel = 3'd0;
      mem_req_op.on      = 1'b0;
    end
  end
  assign pix_ready = mem_req_ready && (state == T_DRAW);

  mfb_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk       (clk),
    .rst       (rst),
    .req_valid (mem_req_valid),
    .req_ready (mem_req_ready),
    .req_addr  (mem_req_addr),
    .req_op    (mem_req_op),
    .rd_valid  (mem_rd_valid),
    .rd_data   (mem_rd_data),
    .clearing  (clearing)
  );

  // Checks on the command sequencing.
  `MFB_ASSERT_NEXT(a_out_drop, out_valid && out_ready, !out_valid, "result shown twice")
  `MFB_ASSERT_SAME(a_err_level, out_valid && error, op_q == OP_LEVEL, "error on non-bar")
  `MFB_ASSERT_SAME(a_data_read, out_valid && (read_data != 8'd0), op_q == OP_READ, "stray data")
  `MFB_ASSERT_SAME(a_idle_walker, in_ready, !walk_busy, "walker busy while idle")

endmodule
